FILE: rtl/core/sbl_pkg.sv
// Shared constants, register codes and controller/datapath handshake types
// for the Sobel edge filter. No dependencies.
package sbl_pkg;

   localparam int MAX_WIDTH_DEF = 1024;
   localparam int HEIGHT_LIMIT  = 4096;

   localparam int PIX_W      = 8;
   localparam int ROW_W      = 12;
   localparam int COL_OUT_W  = 10;
   localparam int VAL_W      = 12;
   localparam int WREG_W     = 11;
   localparam int HREG_W     = 13;
   localparam int MODE_W     = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   // square root of h*h + v*v
   localparam int SQ_W   = 20;
   localparam int ROOT_W = 11;
   localparam int RAD_W  = 2 * ROOT_W;
   localparam int REM_W  = ROOT_W + 1;
   localparam int CNT_W  = $clog2(ROOT_W + 1);

   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE   = 2'd2;

   localparam logic [MODE_W-1:0] MODE_HORIZ = 2'd0;
   localparam logic [MODE_W-1:0] MODE_VERT  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_MAG   = 2'd2;

   localparam logic [WREG_W-1:0] WIDTH_RESET  = 11'd512;
   localparam logic [HREG_W-1:0] HEIGHT_RESET = 13'd512;

   typedef struct packed {
      logic load;        // accept pixel, read line stores
      logic grad;        // form gradients, write line stores, advance counters
      logic square;      // register h*h and v*v
      logic root_start;  // load the square-root unit
      logic load_out;    // move result into the output register
   } sbl_cmd_type;

   typedef struct packed {
      logic emit;        // current centre is interior
      logic magnitude;   // mode selects magnitude
      logic root_busy;
      logic out_free;    // output register can take a result
   } sbl_status_type;

endpackage

FILE: rtl/core/sbl_if.sv
// Channel interfaces of the Sobel edge filter: pixel input, result output
// and register write port. Depends on sbl_pkg.
interface sbl_pixel_if import sbl_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel;
   modport source (output valid, pixel, input ready);
   modport sink   (input valid, pixel, output ready);
endinterface

interface sbl_result_if import sbl_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [ROW_W-1:0]        center_row;
   logic [COL_OUT_W-1:0]    center_col;
   logic signed [VAL_W-1:0] value;
   logic                    frame_end;
   modport source (output valid, center_row, center_col, value, frame_end, input ready);
   modport sink   (input valid, center_row, center_col, value, frame_end, output ready);
endinterface

interface sbl_csr_if import sbl_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/sobel_edge_filter.sv
// Sobel 3x3 edge filter, top level. Depends on sbl_pkg, sbl_if, sbl_ctrl, sbl_datapath.
// One pixel at a time: a border centre passes only the gradient state; an interior
// centre passes it and then the output state, which waits for a free output register
// and loads the result; magnitude mode runs the square, start and 11-step square-root
// states between them. Reset (synchronous) clears counters, window, handshake state and
// restores register defaults; line stores are not cleared and need no clearing pass.
module sobel_edge_filter import sbl_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   sbl_pixel_if.sink     req_if,
   sbl_result_if.source  rsp_if,
   sbl_csr_if.sink       csr_if
);

   sbl_cmd_type    cmd;
   sbl_status_type status;
   logic           req_ready;

   assign req_if.ready = req_ready;
   assign csr_if.ready = 1'b1;

   sbl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sbl_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .pixel         (req_if.pixel),
      .csr_write     (csr_if.valid && csr_if.ready),
      .csr_index     (csr_if.index),
      .csr_data      (csr_if.data),
      .rsp_valid     (rsp_if.valid),
      .rsp_ready     (rsp_if.ready),
      .rsp_row       (rsp_if.center_row),
      .rsp_col       (rsp_if.center_col),
      .rsp_value     (rsp_if.value),
      .rsp_frame_end (rsp_if.frame_end)
   );

   // one pixel in flight: ready drops right after a transfer
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_ready) |=> !req_ready)
      else $error("input taken while a pixel is in flight");

   a_root_runs: assert property (@(posedge clock) disable iff (reset)
      cmd.root_start |=> status.root_busy)
      else $error("square-root unit did not start");

   a_root_mode: assert property (@(posedge clock) disable iff (reset)
      cmd.root_start |-> status.magnitude && status.emit)
      else $error("square root started outside magnitude mode");

   a_interior_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.ready) |-> (rsp_if.center_row != '0))
      else $error("result transfer for a border row");

endmodule

FILE: rtl/core/sbl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sbl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/sbl_sqrt.sv
// Iterative integer square root of a + b, one result bit per cycle.
// Depends on sbl_pkg.
module sbl_sqrt import sbl_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [SQ_W-1:0]   operand_a,
   input  logic [SQ_W-1:0]   operand_b,
   output logic              busy,
   output logic [ROOT_W-1:0] root
);

   logic [RAD_W-1:0]  rad_ff,  rad_in;
   logic [REM_W-1:0]  rem_ff,  rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [CNT_W-1:0]  cnt_ff,  cnt_in;
   logic [REM_W+1:0]  rem_sh;
   logic [REM_W+1:0]  trial;

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      rem_sh  = {rem_ff, rad_ff[RAD_W-1 -: 2]};
      trial   = {1'b0, root_ff, 2'b01};
      if (start) begin
         rad_in  = RAD_W'({1'b0, operand_a} + {1'b0, operand_b});
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CNT_W'(ROOT_W);
      end else if (cnt_ff != '0) begin
         rad_in = {rad_ff[RAD_W-3:0], 2'b00};
         cnt_in = cnt_ff - 1'b1;
         if (rem_sh >= trial) begin
            rem_in  = REM_W'(rem_sh - trial);
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh[REM_W-1:0];
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign busy = (cnt_ff != '0);
   assign root = root_ff;

endmodule

FILE: rtl/core/sbl_ctrl.sv
// Sequencing state machine of the Sobel edge filter: one pixel at a time
// through gradient, optional square root and output load. Depends on sbl_pkg.
module sbl_ctrl import sbl_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  sbl_status_type status,
   output sbl_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GRAD,
      ST_SQUARE,
      ST_START,
      ST_ROOT,
      ST_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.load = ready_ff && req_valid;
            if (cmd.load) begin
               state_in = ST_GRAD;
            end
         end
         ST_GRAD: begin
            cmd.grad = 1'b1;
            if (!status.emit) begin
               state_in = ST_IDLE;
            end else if (status.magnitude) begin
               state_in = ST_SQUARE;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = ST_START;
         end
         ST_START: begin
            cmd.root_start = 1'b1;
            state_in       = ST_ROOT;
         end
         ST_ROOT: begin
            if (!status.root_busy) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == ST_IDLE);
      end
   end

   assign req_ready = ready_ff;

endmodule

FILE: rtl/core/sbl_datapath.sv
// Datapath of the Sobel edge filter: registers, counters, line stores,
// 3x3 window, gradients, squares, square root and output register.
// Depends on sbl_pkg, sbl_ram and sbl_sqrt.
module sbl_datapath import sbl_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  sbl_cmd_type             cmd,
   output sbl_status_type          status,
   input  logic [PIX_W-1:0]        pixel,
   input  logic                    csr_write,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [ROW_W-1:0]        rsp_row,
   output logic [COL_OUT_W-1:0]    rsp_col,
   output logic signed [VAL_W-1:0] rsp_value,
   output logic                    rsp_frame_end
);

   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int WW   = $clog2(MAX_WIDTH + 1);
   localparam int CMPW = (WW > WREG_W) ? WW : WREG_W;

   logic [WREG_W-1:0] width_ff;
   logic [HREG_W-1:0] height_ff;
   logic [MODE_W-1:0] mode_ff;

   logic [CW-1:0]    col_ff, cc_ff, cc;
   logic [ROW_W-1:0] row_ff, rc_ff, rc;
   logic [PIX_W-1:0] pix_ff;
   logic [PIX_W-1:0] win_ff [6];
   logic [PIX_W-1:0] top, mid;

   logic [CMPW-1:0]   weff, wlast, cc_ext, col_ext;
   logic [HREG_W-1:0] heff, hlast;
   logic              col_last, row_last;

   logic signed [VAL_W-1:0] lt, lm, lb, ct, cb, tp, md, bt;
   logic signed [VAL_W-1:0] gh, gv, gh_ff, gv_ff;
   logic signed [2*VAL_W-1:0] ph, pv;
   logic [SQ_W-1:0]         sq_h_ff, sq_v_ff;
   logic [ROW_W-1:0]        orow_ff;
   logic [COL_OUT_W-1:0]    ocol_ff;
   logic                    fe_ff;
   logic [CMPW-1:0]         cm1;
   logic                    root_busy;
   logic [ROOT_W-1:0]       root;

   logic                    rsp_valid_ff;
   logic [ROW_W-1:0]        rsp_row_ff;
   logic [COL_OUT_W-1:0]    rsp_col_ff;
   logic signed [VAL_W-1:0] rsp_value_ff, value_sel;
   logic                    rsp_fe_ff;

   // effective geometry, saturated to the supported range
   always_comb begin
      col_ext = CMPW'(width_ff);
      if (col_ext < CMPW'(3)) begin
         weff = CMPW'(3);
      end else if (col_ext > CMPW'(MAX_WIDTH)) begin
         weff = CMPW'(MAX_WIDTH);
      end else begin
         weff = col_ext;
      end
      if (height_ff < HREG_W'(3)) begin
         heff = HREG_W'(3);
      end else if (height_ff > HREG_W'(HEIGHT_LIMIT)) begin
         heff = HREG_W'(HEIGHT_LIMIT);
      end else begin
         heff = height_ff;
      end
      wlast = weff - 1'b1;
      hlast = heff - 1'b1;
   end

   // position of the pixel being accepted
   always_comb begin
      if (CMPW'(col_ff) >= weff) begin
         cc = CW'(wlast);
      end else begin
         cc = col_ff;
      end
      if (HREG_W'(row_ff) >= heff) begin
         rc = ROW_W'(hlast);
      end else begin
         rc = row_ff;
      end
   end

   assign cc_ext   = CMPW'(cc_ff);
   assign col_last = (cc_ext == wlast);
   assign row_last = (HREG_W'(rc_ff) == hlast);
   assign cm1      = cc_ext - 1'b1;

   sbl_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
      .clock   (clock),
      .wr_en   (cmd.grad),
      .wr_addr (cc_ff),
      .wr_data (mid),
      .rd_en   (cmd.load),
      .rd_addr (cc),
      .rd_data (top)
   );

   sbl_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
      .clock   (clock),
      .wr_en   (cmd.grad),
      .wr_addr (cc_ff),
      .wr_data (pix_ff),
      .rd_en   (cmd.load),
      .rd_addr (cc),
      .rd_data (mid)
   );

   always_comb begin
      lt = signed'(VAL_W'(win_ff[0]));
      lm = signed'(VAL_W'(win_ff[1]));
      lb = signed'(VAL_W'(win_ff[2]));
      ct = signed'(VAL_W'(win_ff[3]));
      cb = signed'(VAL_W'(win_ff[5]));
      tp = signed'(VAL_W'(top));
      md = signed'(VAL_W'(mid));
      bt = signed'(VAL_W'(pix_ff));
      gh = lt + (lm <<< 1) + lb - tp - (md <<< 1) - bt;
      gv = lt + (ct <<< 1) + tp - lb - (cb <<< 1) - bt;
      ph = gh_ff * gh_ff;
      pv = gv_ff * gv_ff;
   end

   always_comb begin
      case (mode_ff)
         MODE_HORIZ: value_sel = gh_ff;
         MODE_VERT:  value_sel = gv_ff;
         default:    value_sel = signed'(VAL_W'(root));
      endcase
   end

   sbl_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.root_start),
      .operand_a (sq_h_ff),
      .operand_b (sq_v_ff),
      .busy      (root_busy),
      .root      (root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         mode_ff      <= MODE_MAG;
         col_ff       <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_WIDTH: begin
                  width_ff <= csr_data[WREG_W-1:0];
                  col_ff   <= '0;
                  row_ff   <= '0;
               end
               CSR_HEIGHT: begin
                  height_ff <= csr_data[HREG_W-1:0];
                  col_ff    <= '0;
                  row_ff    <= '0;
               end
               CSR_MODE: begin
                  mode_ff <= csr_data[MODE_W-1:0];
               end
               default: begin
               end
            endcase
         end
         if (cmd.grad) begin
            win_ff[0] <= win_ff[3];
            win_ff[1] <= win_ff[4];
            win_ff[2] <= win_ff[5];
            win_ff[3] <= top;
            win_ff[4] <= mid;
            win_ff[5] <= pix_ff;
            if (col_last) begin
               col_ff <= '0;
               row_ff <= row_last ? '0 : rc_ff + 1'b1;
            end else begin
               col_ff <= cc_ff + 1'b1;
               row_ff <= rc_ff;
            end
         end
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (cmd.load) begin
         pix_ff <= pixel;
         cc_ff  <= cc;
         rc_ff  <= rc;
      end
      if (cmd.grad) begin
         gh_ff   <= gh;
         gv_ff   <= gv;
         orow_ff <= rc_ff - 1'b1;
         ocol_ff <= cm1[COL_OUT_W-1:0];
         fe_ff   <= row_last && col_last;
      end
      if (cmd.square) begin
         sq_h_ff <= ph[SQ_W-1:0];
         sq_v_ff <= pv[SQ_W-1:0];
      end
      if (cmd.load_out) begin
         rsp_row_ff   <= orow_ff;
         rsp_col_ff   <= ocol_ff;
         rsp_value_ff <= value_sel;
         rsp_fe_ff    <= fe_ff;
      end
   end

   always_comb begin
      status.emit      = (rc_ff >= ROW_W'(2)) && (cc_ext >= CMPW'(2));
      status.magnitude = mode_ff[1];
      status.root_busy = root_busy;
      status.out_free  = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_row       = rsp_row_ff;
   assign rsp_col       = rsp_col_ff;
   assign rsp_value     = rsp_value_ff;
   assign rsp_frame_end = rsp_fe_ff;

endmodule
